// ===== hw/rtl/vrot_pkg.sv =====
// Shared types and constants of the vertex axis rotation unit.
package vrot_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int WORK_WIDTH      = 64;
   localparam int GUARD_BITS      = 60 - COORD_WIDTH;
   localparam int SIGN_BITS       = WORK_WIDTH - COORD_WIDTH - GUARD_BITS;
   localparam int TURN_WIDTH      = 32;
   localparam int CORDIC_STEPS    = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [31:0] CORDIC_GAIN = 32'h9B74_EDA8;

   // arctangent of 2^-i as a fraction of a full turn, 2^32 = one turn
   localparam logic [31:0] ATAN_TABLE [0:CORDIC_STEPS-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AXIS  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ANGLE = 2'd1;

   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] coord_x;
      logic signed [COORD_WIDTH-1:0] coord_y;
      logic signed [COORD_WIDTH-1:0] coord_z;
      logic                          last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] result_x;
      logic signed [COORD_WIDTH-1:0] result_y;
      logic signed [COORD_WIDTH-1:0] result_z;
      logic                          end_of_buffer;
   } rsp_type;

endpackage

// ===== hw/rtl/vertex_axis_rotation_unit.sv =====
// Top level of the vertex axis rotation unit: pipelined CORDIC plane rotation.
//
//   channel | direction | handshake           | beat
//   --------+-----------+---------------------+-------------------------------
//   req     | in        | req_valid/req_stall | vrot_pkg::req_type vertex
//   rsp     | out       | rsp_valid/rsp_stall | vrot_pkg::rsp_type vertex
//   csr     | in        | csr_we              | axis (index 0), angle (index 1)
//
// One beat enters per cycle while the output is not stalled; the pipe is an entry stage
// (axis pick and quarter-turn swap), 32 CORDIC stages (one micro-rotation each), four gain
// stages (magnitude, 32x32 partial products, sum, sign) and the round/saturate output register.
// Reset (synchronous) clears all valid bits and sets axis z, angle zero.
// A stalled output beat freezes the whole pipe; nothing is lost or repeated.
module vertex_axis_rotation_unit #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  vrot_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output vrot_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [vrot_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ANGLE_WIDTH-1:0]               csr_wdata
);

   localparam int CW     = vrot_pkg::COORD_WIDTH;
   localparam int WW     = vrot_pkg::WORK_WIDTH;
   localparam int GB     = vrot_pkg::GUARD_BITS;
   localparam int NSTEP  = vrot_pkg::CORDIC_STEPS;
   // entry + CORDIC stages, then four gain stages
   localparam int STAGES = NSTEP + 5;
   localparam int S_FIN1 = NSTEP + 1;
   localparam int S_FIN4 = NSTEP + 4;

   typedef struct packed {
      logic signed [WW-1:0] a;
      logic signed [WW-1:0] b;
      logic signed [31:0]   ang;
   } cordic_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 last;
      vrot_pkg::axis_type   axis;
   } side_type;

   // configuration
   vrot_pkg::axis_type   axis_ff;
   logic [ANGLE_WIDTH-1:0] angle_ff;

   // pipeline
   logic [STAGES-1:0]    valid_ff;
   side_type             side_ff    [0:STAGES-1];
   cordic_type           cordic_ff  [0:NSTEP];
   cordic_type           cordic_in  [0:NSTEP];
   cordic_type           entry_in;
   logic [WW-1:0]        mag_ff     [0:1];
   logic                 neg1_ff    [0:1];
   logic [WW-1:0]        prod_hi_ff [0:1];
   logic [WW-1:0]        prod_lo_ff [0:1];
   logic                 neg2_ff    [0:1];
   logic [WW-1:0]        sum_ff     [0:1];
   logic                 neg3_ff    [0:1];
   logic signed [WW-1:0] signed_ff  [0:1];
   logic                 rsp_valid_ff;
   vrot_pkg::rsp_type    rsp_ff;
   vrot_pkg::rsp_type    rsp_in;

   logic                 advance;
   side_type             side_in;
   logic signed [CW-1:0] a_sel, b_sel;
   logic signed [WW-1:0] a_wide, b_wide;
   logic [31:0]          turn, centred;
   logic signed [CW-1:0] lane_out [0:1];

   // Freeze everything while the output beat waits.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff  <= vrot_pkg::AXIS_Z;
         angle_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            vrot_pkg::REG_AXIS:  axis_ff  <= vrot_pkg::axis_type'(csr_wdata[1:0]);
            vrot_pkg::REG_ANGLE: angle_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Entry: pick the plane pair, scale up by the guard bits, resolve the quadrant.
   always_comb begin
      side_in = '{x: req_data.coord_x, y: req_data.coord_y, z: req_data.coord_z,
                  last: req_data.last_vertex, axis: axis_ff};
      case (axis_ff)
         vrot_pkg::AXIS_X: begin
            a_sel = req_data.coord_z;
            b_sel = req_data.coord_y;
         end
         vrot_pkg::AXIS_Y: begin
            a_sel = req_data.coord_z;
            b_sel = req_data.coord_x;
         end
         default: begin
            a_sel = req_data.coord_x;
            b_sel = req_data.coord_y;
         end
      endcase
      a_wide = {{vrot_pkg::SIGN_BITS{a_sel[CW-1]}}, a_sel, {GB{1'b0}}};
      b_wide = {{vrot_pkg::SIGN_BITS{b_sel[CW-1]}}, b_sel, {GB{1'b0}}};

      turn    = {angle_ff, {(vrot_pkg::TURN_WIDTH-ANGLE_WIDTH){1'b0}}};
      centred = turn + 32'h2000_0000;
      // residual in [-2^29, 2^29)
      entry_in.ang = {{3{~centred[29]}}, centred[28:0]};
      case (centred[31:30])
         2'd1: begin
            entry_in.a = -b_wide;
            entry_in.b = a_wide;
         end
         2'd2: begin
            entry_in.a = -a_wide;
            entry_in.b = -b_wide;
         end
         2'd3: begin
            entry_in.a = b_wide;
            entry_in.b = -a_wide;
         end
         default: begin
            entry_in.a = a_wide;
            entry_in.b = b_wide;
         end
      endcase
   end

   // One micro-rotation per stage, floor shifts.
   always_comb begin
      cordic_in[0] = entry_in;
      for (int k = 1; k <= NSTEP; k++) begin
         if (!cordic_ff[k-1].ang[31]) begin
            cordic_in[k].a   = cordic_ff[k-1].a - (cordic_ff[k-1].b >>> (k-1));
            cordic_in[k].b   = cordic_ff[k-1].b + (cordic_ff[k-1].a >>> (k-1));
            cordic_in[k].ang = cordic_ff[k-1].ang - signed'(vrot_pkg::ATAN_TABLE[k-1]);
         end else begin
            cordic_in[k].a   = cordic_ff[k-1].a + (cordic_ff[k-1].b >>> (k-1));
            cordic_in[k].b   = cordic_ff[k-1].b - (cordic_ff[k-1].a >>> (k-1));
            cordic_in[k].ang = cordic_ff[k-1].ang + signed'(vrot_pkg::ATAN_TABLE[k-1]);
         end
      end
   end

   // Output: round to nearest (ties up), drop guard bits, saturate, route to axes.
   always_comb begin
      logic signed [WW-1:0] rounded;
      logic signed [WW-1:0] shifted;
      logic                 fits;
      for (int l = 0; l < 2; l++) begin
         rounded = signed_ff[l] + (WW'(1) <<< (GB - 1));
         shifted = rounded >>> GB;
         fits    = (&shifted[WW-1:CW-1]) || !(|shifted[WW-1:CW-1]);
         if (fits) begin
            lane_out[l] = shifted[CW-1:0];
         end else if (shifted[WW-1]) begin
            lane_out[l] = {1'b1, {(CW-1){1'b0}}};
         end else begin
            lane_out[l] = {1'b0, {(CW-1){1'b1}}};
         end
      end
      rsp_in.result_x      = side_ff[S_FIN4].x;
      rsp_in.result_y      = side_ff[S_FIN4].y;
      rsp_in.result_z      = side_ff[S_FIN4].z;
      rsp_in.end_of_buffer = side_ff[S_FIN4].last;
      case (side_ff[S_FIN4].axis)
         vrot_pkg::AXIS_X: begin
            rsp_in.result_z = lane_out[0];
            rsp_in.result_y = lane_out[1];
         end
         vrot_pkg::AXIS_Y: begin
            rsp_in.result_z = lane_out[0];
            rsp_in.result_x = lane_out[1];
         end
         vrot_pkg::AXIS_Z: begin
            rsp_in.result_x = lane_out[0];
            rsp_in.result_y = lane_out[1];
         end
         default: ;
      endcase
   end

   // Control: valid bits advance with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[STAGES-2:0], req_valid};
         rsp_valid_ff <= valid_ff[STAGES-1];
      end
   end

   // Payload: no reset, hold while frozen.
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < STAGES; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         for (int k = 0; k <= NSTEP; k++) begin
            cordic_ff[k] <= cordic_in[k];
         end
         for (int l = 0; l < 2; l++) begin
            logic signed [WW-1:0] v;
            v = (l == 0) ? cordic_ff[NSTEP].a : cordic_ff[NSTEP].b;
            // gain: magnitude, then hi and lo partial products, then sum and sign
            neg1_ff[l]    <= v[WW-1];
            mag_ff[l]     <= v[WW-1] ? WW'(-v) : WW'(v);
            neg2_ff[l]    <= neg1_ff[l];
            prod_hi_ff[l] <= WW'(mag_ff[l][WW-1:32]) * WW'(vrot_pkg::CORDIC_GAIN);
            prod_lo_ff[l] <= WW'(mag_ff[l][31:0]) * WW'(vrot_pkg::CORDIC_GAIN);
            neg3_ff[l]    <= neg2_ff[l];
            sum_ff[l]     <= prod_hi_ff[l] + {32'd0, prod_lo_ff[l][WW-1:32]};
            signed_ff[l]  <= neg3_ff[l] ? -signed'(sum_ff[l]) : signed'(sum_ff[l]);
         end
         rsp_ff <= rsp_in;
      end
   end

   // A frozen pipe keeps every valid bit in place.
   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(valid_ff))
      else $error("pipeline moved while output was stalled");

   // A result shows up only out of the last gain stage.
   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(valid_ff[STAGES-1]))
      else $error("result beat appeared without a source");

   // An accepted beat lands in the entry stage.
   a_entry: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted beat lost at entry");

   // The first gain stage sits right after the CORDIC stages.
   a_fin_order: assert property (@(posedge clock) disable iff (reset)
      (advance && valid_ff[NSTEP]) |=> valid_ff[S_FIN1])
      else $error("beat lost between rotation and gain stages");

endmodule
